// ===== design/length_prefixed_frame_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Length-prefixed frame parser assertion macros
// Shared forms for the concurrent checks of the frame parser.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lpfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame parser package
// Types, register indexes, event codes and defaults of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfp_pkg;

	localparam int LPFP_ID_COUNT    = 32;
	localparam int LPFP_QUEUE_DEPTH = 2;
	localparam int LPFP_CFG_IDX_W   = 8;

	localparam logic [LPFP_CFG_IDX_W-1:0] REG_HEADER_FIRST   = 8'd0;
	localparam logic [LPFP_CFG_IDX_W-1:0] REG_HEADER_SECOND  = 8'd1;
	localparam logic [LPFP_CFG_IDX_W-1:0] REG_ID_ENABLE_MASK = 8'd2;
	localparam logic [LPFP_CFG_IDX_W-1:0] REG_MAX_LENGTH     = 8'd3;

	localparam logic [7:0]  RST_HEADER_FIRST  = 8'hAA;
	localparam logic [7:0]  RST_HEADER_SECOND = 8'h55;
	localparam logic [31:0] RST_ID_MASK       = 32'h0;
	localparam logic [15:0] RST_MAX_LENGTH    = 16'd1024;

	localparam logic [7:0] ID_BIG_ENDIAN    = 8'hFF;
	localparam logic [7:0] ID_LITTLE_ENDIAN = 8'hFE;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_BYTE   = 3'd1,
		EV_EMPTY  = 3'd2,
		EV_BIG    = 3'd3,
		EV_LITTLE = 3'd4,
		EV_BADID  = 3'd5,
		EV_LENERR = 3'd6
	} lpfp_event_t;

	typedef struct packed {
		logic [7:0]  header_first;
		logic [7:0]  header_second;
		logic [31:0] id_enable_mask;
		logic [15:0] max_length;
	} lpfp_cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_head1;
		logic       is_head2;
		logic       is_big;
		logic       is_little;
		logic       id_ok;
	} lpfp_class_t;

endpackage

`default_nettype wire

// ===== design/lpfp_in_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/lpfp_out_if.sv =====
// ----------------------------------------------------------------------------
// Parser result channel
// Valid/ready channel that carries one parser result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  frame_id;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [15:0] frame_length;
	logic        frame_end;

	modport source (output valid, output event_res, output frame_id, output payload_byte,
		output payload_index, output frame_length, output frame_end, input ready);
	modport sink (input valid, input event_res, input frame_id, input payload_byte,
		input payload_index, input frame_length, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== design/lpfp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lpfp_regs.sv =====
// ----------------------------------------------------------------------------
// Frame parser configuration registers
// Holds the header values, the id enable mask and the length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lpfp_cfg_if.sink          cfg,
	output lpfp_pkg::lpfp_cfg_t regs
);
	import lpfp_pkg::*;

	lpfp_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.header_first   <= RST_HEADER_FIRST;
			regs_q.header_second  <= RST_HEADER_SECOND;
			regs_q.id_enable_mask <= RST_ID_MASK;
			regs_q.max_length     <= RST_MAX_LENGTH;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HEADER_FIRST:   regs_q.header_first   <= cfg.data[7:0];
				REG_HEADER_SECOND:  regs_q.header_second  <= cfg.data[7:0];
				REG_ID_ENABLE_MASK: regs_q.id_enable_mask <= cfg.data;
				REG_MAX_LENGTH:     regs_q.max_length     <= cfg.data[15:0];
				default: ;
			endcase
		end
	end
endmodule

`default_nettype wire

// ===== design/lpfp_front.sv =====
// ----------------------------------------------------------------------------
// Frame parser front end
// Accepts received bytes and tags each with its header and id matches.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_front #(
	parameter int ID_COUNT = lpfp_pkg::LPFP_ID_COUNT
) (
	lpfp_in_if.sink                   rx,
	input  wire lpfp_pkg::lpfp_cfg_t  regs,
	input  wire logic                 queue_full,
	output logic                      push,
	output lpfp_pkg::lpfp_class_t     push_item
);
	import lpfp_pkg::*;

	logic id_in_range;

	assign rx.ready = !queue_full;
	assign push     = rx.valid && !queue_full;

	assign id_in_range = {1'b0, rx.rx_byte} < 9'(ID_COUNT);

	always_comb begin
		push_item.rx_byte   = rx.rx_byte;
		push_item.is_head1  = rx.rx_byte == regs.header_first;
		push_item.is_head2  = rx.rx_byte == regs.header_second;
		push_item.is_big    = rx.rx_byte == ID_BIG_ENDIAN;
		push_item.is_little = rx.rx_byte == ID_LITTLE_ENDIAN;
		push_item.id_ok     = id_in_range && regs.id_enable_mask[rx.rx_byte[4:0]];
	end
endmodule

`default_nettype wire

// ===== design/lpfp_queue.sv =====
// ----------------------------------------------------------------------------
// Frame parser item queue
// Short first-in first-out queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_queue #(
	parameter int DEPTH = lpfp_pkg::LPFP_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire lpfp_pkg::lpfp_class_t push_item,
	input  wire logic                  pop,
	output logic                       full,
	output logic                       not_empty,
	output lpfp_pkg::lpfp_class_t      head_item
);
	import lpfp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lpfp_class_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

`default_nettype wire

// ===== design/lpfp_back.sv =====
// ----------------------------------------------------------------------------
// Frame parser back end
// Runs the frame state machine on tagged bytes and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lpfp_pkg::lpfp_cfg_t   regs,
	input  wire logic                  item_valid,
	input  wire lpfp_pkg::lpfp_class_t item,
	output logic                       pop,
	lpfp_out_if.source                 res
);
	import lpfp_pkg::*;

	typedef enum logic [4:0] {
		PH_HEAD1 = 5'b00001,
		PH_HEAD2 = 5'b00010,
		PH_ID    = 5'b00100,
		PH_LEN   = 5'b01000,
		PH_DATA  = 5'b10000
	} lpfp_phase_t;

	lpfp_phase_t phase_q, phase_d;
	logic        big_q, big_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic        seen_q, seen_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] cnt_inc;

	lpfp_event_t ev_d, ev_q;
	logic [7:0]  pbyte_d, pbyte_q;
	logic [15:0] pidx_d, pidx_q;
	logic        fend_d, fend_q;
	logic        res_valid_q;

	assign pop     = item_valid && (!res_valid_q || res.ready);
	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		big_d   = big_q;
		id_d    = id_q;
		len_d   = len_q;
		seen_d  = seen_q;
		cnt_d   = cnt_q;
		ev_d    = EV_NONE;
		pbyte_d = '0;
		pidx_d  = '0;
		fend_d  = 1'b0;
		case (phase_q)
			PH_HEAD2: begin
				phase_d = item.is_head2 ? PH_ID : PH_HEAD1;
			end
			PH_ID: begin
				id_d = item.rx_byte;
				if (item.is_big) begin
					big_d   = 1'b1;
					ev_d    = EV_BIG;
					phase_d = PH_HEAD1;
				end else if (item.is_little) begin
					big_d   = 1'b0;
					ev_d    = EV_LITTLE;
					phase_d = PH_HEAD1;
				end else if (item.id_ok) begin
					seen_d  = 1'b0;
					phase_d = PH_LEN;
				end else begin
					ev_d    = EV_BADID;
					phase_d = PH_HEAD1;
				end
			end
			PH_LEN: begin
				if (!seen_q) begin
					len_d  = {8'h00, item.rx_byte};
					seen_d = 1'b1;
				end else begin
					len_d  = big_q ? {len_q[7:0], item.rx_byte} : {item.rx_byte, len_q[7:0]};
					seen_d = 1'b0;
					cnt_d  = '0;
					if (len_d > regs.max_length) begin
						ev_d    = EV_LENERR;
						phase_d = PH_HEAD1;
					end else if (len_d == '0) begin
						ev_d    = EV_EMPTY;
						fend_d  = 1'b1;
						phase_d = PH_HEAD1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				ev_d    = EV_BYTE;
				pbyte_d = item.rx_byte;
				pidx_d  = cnt_q;
				cnt_d   = cnt_inc;
				if (cnt_inc >= len_q) begin
					fend_d  = 1'b1;
					cnt_d   = '0;
					phase_d = PH_HEAD1;
				end
			end
			default: begin
				phase_d = item.is_head1 ? PH_HEAD2 : PH_HEAD1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEAD1;
			big_q       <= 1'b1;
			id_q        <= '0;
			len_q       <= '0;
			seen_q      <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				big_q   <= big_d;
				id_q    <= id_d;
				len_q   <= len_d;
				seen_q  <= seen_d;
				cnt_q   <= cnt_d;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q    <= ev_d;
			pbyte_q <= pbyte_d;
			pidx_q  <= pidx_d;
			fend_q  <= fend_d;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.event_res     = ev_q;
	assign res.frame_id      = id_q;
	assign res.payload_byte  = pbyte_q;
	assign res.payload_index = pidx_q;
	assign res.frame_length  = len_q;
	assign res.frame_end     = fend_q;
endmodule

`default_nettype wire

// ===== design/length_prefixed_frame_parser_unit.sv =====
// An accepted byte goes into the item queue, then into the registered result.
// The parser takes one byte per cycle while the result channel is not stalled.
// While a result waits, input continues until the two-entry queue is full.
// Reset (arst_n low) restores the register defaults and the hunting state at once.
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// Hunts for a two-byte header, reads id and length, streams the payload.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_parser_unit #(
	parameter int ID_COUNT    = lpfp_pkg::LPFP_ID_COUNT,
	parameter int QUEUE_DEPTH = lpfp_pkg::LPFP_QUEUE_DEPTH
) (
	input wire logic   clk,
	input wire logic   arst_n,
	lpfp_in_if.sink    rx,
	lpfp_out_if.source result,
	lpfp_cfg_if.sink   cfg
);
	import lpfp_pkg::*;

	lpfp_cfg_t   regs;
	logic        push;
	lpfp_class_t push_item;
	logic        pop;
	logic        queue_full;
	logic        queue_not_empty;
	lpfp_class_t head_item;

	lpfp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lpfp_front #(
		.ID_COUNT (ID_COUNT)
	) u_front (
		.rx         (rx),
		.regs       (regs),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	lpfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head_item (head_item)
	);

	lpfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.item_valid (queue_not_empty),
		.item       (head_item),
		.pop        (pop),
		.res        (result)
	);
endmodule

`default_nettype wire

// ===== design/lpfp_checker.sv =====
// ----------------------------------------------------------------------------
// Frame parser port checker
// Checks the result channel of the frame parser over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_frame_parser_unit_assert.svh"

module lpfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  event_res,
	input wire logic [7:0]  frame_id,
	input wire logic [7:0]  payload_byte,
	input wire logic [15:0] payload_index,
	input wire logic [15:0] frame_length,
	input wire logic        frame_end
);
	import lpfp_pkg::*;

	// A stalled result holds all of its fields.
	`LPFP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(frame_id) && $stable(payload_byte) && $stable(payload_index) && $stable(frame_length) && $stable(frame_end), "stalled result changed")

	// A frame ends only on a payload byte or on an empty frame.
	`LPFP_ASSERT_NOW(a_end_event, clk, arst_n, out_valid && frame_end, event_res == EV_BYTE || event_res == EV_EMPTY, "frame end on wrong event")

	// Payload fields are zero unless a payload byte is reported.
	`LPFP_ASSERT_NOW(a_payload_zero, clk, arst_n, out_valid && event_res != EV_BYTE, payload_byte == 8'h00 && payload_index == 16'h0000, "payload fields not zero")

	// A payload byte lies inside the decoded length.
	`LPFP_ASSERT_NOW(a_index_range, clk, arst_n, out_valid && event_res == EV_BYTE, payload_index < frame_length && (frame_end == (payload_index + 16'd1 == frame_length)), "payload index out of frame")
endmodule

bind length_prefixed_frame_parser_unit lpfp_checker u_lpfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.event_res     (result.event_res),
	.frame_id      (result.frame_id),
	.payload_byte  (result.payload_byte),
	.payload_index (result.payload_index),
	.frame_length  (result.frame_length),
	.frame_end     (result.frame_end)
);

`default_nettype wire

// ===== verif/length_prefixed_frame_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Frame parser testbench
// Drives received bytes into the frame parser with random gaps on both
// channels, predicts every result from a shadow copy of the parser state and
// registers, and checks each result in order. Frames under reset defaults
// come first, then directed bytes, a length limit test, a receiver hold-off
// that fills the block, then random frames under several register settings.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfp_pkg::*;

	localparam int CYCLE_LIMIT        = 200000;
	localparam int MAX_REPORTS        = 10;
	localparam int MAX_GAP            = 16;
	localparam int RANDOM_PHASE_ITEMS = 80;
	localparam int PRESSURE_ITEMS     = 40;
	localparam int HOLD_CYCLES        = 400;
	localparam int SETTLE_CYCLES      = 8;
	localparam int DIRECTED_COUNT     = 26;

	localparam logic [LPFP_CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;

	localparam logic [7:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
		RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd31, 8'h00, 8'h00,
		RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd0, 8'h00, 8'h02, 8'h00, 8'hFF,
		RST_HEADER_FIRST, RST_HEADER_FIRST, RST_HEADER_SECOND,
		RST_HEADER_FIRST, RST_HEADER_SECOND, 8'(LPFP_ID_COUNT),
		RST_HEADER_FIRST, RST_HEADER_SECOND, ID_LITTLE_ENDIAN,
		RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd1, 8'hFF, 8'hFF
	};

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		READ_ID,
		READ_LENGTH,
		STREAM_PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		lpfp_event_t kind;
		logic [7:0]  id;
		logic [7:0]  data;
		logic [15:0] index;
		logic [15:0] length;
		logic        last;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lpfp_in_if  rx_ch();
	lpfp_out_if result_ch();
	lpfp_cfg_if cfg_ch();

	length_prefixed_frame_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [7:0]   hdr_first_q;
	logic [7:0]   hdr_second_q;
	logic [31:0]  id_mask_q;
	logic [15:0]  max_len_q;

	parse_phase_t phase_q;
	logic         big_endian_q;
	logic [7:0]   cur_id_q;
	logic [15:0]  len_q;
	logic         len_half_q;
	logic [15:0]  pay_count_q;

	frame_result_t expected_results [$];

	int err_count     = 0;
	int cycle_count   = 0;
	int results_seen  = 0;
	int items_sent    = 0;
	bit send_idle     = 1'b1;
	bit recv_idle     = 1'b1;
	bit result_hold   = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic reset_parser_model();
		hdr_first_q  = RST_HEADER_FIRST;
		hdr_second_q = RST_HEADER_SECOND;
		id_mask_q    = RST_ID_MASK;
		max_len_q    = RST_MAX_LENGTH;
		phase_q      = HUNT_FIRST;
		big_endian_q = 1'b1;
		cur_id_q     = '0;
		len_q        = '0;
		len_half_q   = 1'b0;
		pay_count_q  = '0;
	endtask

	function automatic frame_result_t advance_parser(input logic [7:0] b);
		frame_result_t r;
		logic [15:0]   next_count;
		r = '0;
		r.kind = EV_NONE;
		case (phase_q)
			HUNT_SECOND: phase_q = (b == hdr_second_q) ? READ_ID : HUNT_FIRST;
			READ_ID: begin
				cur_id_q = b;
				if (b == ID_BIG_ENDIAN) begin
					big_endian_q = 1'b1;
					r.kind = EV_BIG;
					phase_q = HUNT_FIRST;
				end else if (b == ID_LITTLE_ENDIAN) begin
					big_endian_q = 1'b0;
					r.kind = EV_LITTLE;
					phase_q = HUNT_FIRST;
				end else if (int'(b) < LPFP_ID_COUNT && id_mask_q[b[4:0]]) begin
					len_half_q = 1'b0;
					phase_q = READ_LENGTH;
				end else begin
					r.kind = EV_BADID;
					phase_q = HUNT_FIRST;
				end
			end
			READ_LENGTH: begin
				if (!len_half_q) begin
					len_q = {8'h00, b};
					len_half_q = 1'b1;
				end else begin
					len_q = big_endian_q ? {len_q[7:0], b} : {b, len_q[7:0]};
					len_half_q = 1'b0;
					pay_count_q = '0;
					if (len_q > max_len_q) begin
						r.kind = EV_LENERR;
						phase_q = HUNT_FIRST;
					end else if (len_q == 16'd0) begin
						r.kind = EV_EMPTY;
						r.last = 1'b1;
						phase_q = HUNT_FIRST;
					end else begin
						phase_q = STREAM_PAYLOAD;
					end
				end
			end
			STREAM_PAYLOAD: begin
				r.kind = EV_BYTE;
				r.data = b;
				r.index = pay_count_q;
				next_count = pay_count_q + 16'd1;
				if (next_count >= len_q) begin
					r.last = 1'b1;
					pay_count_q = '0;
					phase_q = HUNT_FIRST;
				end else begin
					pay_count_q = next_count;
				end
			end
			default: phase_q = (b == hdr_first_q) ? HUNT_SECOND : HUNT_FIRST;
		endcase
		r.id = cur_id_q;
		r.length = len_q;
		return r;
	endfunction

	task automatic report_failure(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic check_result();
		frame_result_t exp;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_failure($sformatf("result %0d with nothing expected: kind=%0d id=%h",
				results_seen, result_ch.event_res, result_ch.frame_id));
			return;
		end
		exp = expected_results.pop_front();
		if (result_ch.event_res !== exp.kind || result_ch.frame_id !== exp.id ||
				result_ch.payload_byte !== exp.data || result_ch.payload_index !== exp.index ||
				result_ch.frame_length !== exp.length || result_ch.frame_end !== exp.last) begin
			report_failure($sformatf(
				"result %0d: expected kind=%0d id=%h byte=%h idx=%0d len=%0d end=%b",
				results_seen, exp.kind, exp.id, exp.data, exp.index, exp.length, exp.last));
			if (err_count <= MAX_REPORTS)
				$display("    actual kind=%0d id=%h byte=%h idx=%0d len=%0d end=%b",
					result_ch.event_res, result_ch.frame_id, result_ch.payload_byte,
					result_ch.payload_index, result_ch.frame_length, result_ch.frame_end);
		end
	endtask

	initial begin
		int gap;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (gap != 0 || result_hold) begin
				result_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
				while (result_hold) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			check_result();
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap != 0) begin
			rx_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
		expected_results.push_back(advance_parser(b));
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [LPFP_CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_HEADER_FIRST:   hdr_first_q = value[7:0];
			REG_HEADER_SECOND:  hdr_second_q = value[7:0];
			REG_ID_ENABLE_MASK: id_mask_q = value;
			REG_MAX_LENGTH:     max_len_q = value[15:0];
			default: ;
		endcase
	endtask

	task automatic program_registers(input logic [7:0] h1, input logic [7:0] h2,
			input logic [31:0] mask, input logic [15:0] max_len);
		drain_results();
		write_reg(REG_HEADER_FIRST, {24'h0, h1});
		write_reg(REG_HEADER_SECOND, {24'h0, h2});
		write_reg(REG_ID_ENABLE_MASK, mask);
		write_reg(REG_MAX_LENGTH, {16'h0, max_len});
		write_reg(REG_UNMAPPED, $urandom());
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_other(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == avoid) ? ~b : b;
	endfunction

	function automatic logic [7:0] pick_id();
		logic [7:0] id;
		int         sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return ID_BIG_ENDIAN;
		if (sel == 1)
			return ID_LITTLE_ENDIAN;
		if (sel == 2 || id_mask_q == 32'h0)
			return 8'($urandom_range(0, 255));
		do id = 8'($urandom_range(0, LPFP_ID_COUNT - 1)); while (!id_mask_q[id[4:0]]);
		return id;
	endfunction

	function automatic logic [15:0] pick_length();
		int m;
		m = int'(max_len_q);
		if (m != 65535 && $urandom_range(0, 7) == 0)
			return 16'(m + 1 + $urandom_range(0, 65534 - m));
		if ($urandom_range(0, 9) == 0)
			return 16'd0;
		return 16'($urandom_range(1, 16));
	endfunction

	task automatic send_frame(input logic [7:0] id, input logic [15:0] len);
		send_byte(hdr_first_q);
		send_byte(hdr_second_q);
		send_byte(id);
		if (phase_q == READ_LENGTH) begin
			if (big_endian_q) begin
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end else begin
				send_byte(len[7:0]);
				send_byte(len[15:8]);
			end
			while (phase_q == STREAM_PAYLOAD)
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_broken();
		case ($urandom_range(0, 2))
			0: repeat ($urandom_range(1, 4)) send_byte(pick_other(hdr_first_q));
			1: begin
				send_byte(hdr_first_q);
				send_byte(pick_other(hdr_second_q));
			end
			default: begin
				send_byte(hdr_first_q);
				send_byte(hdr_first_q);
			end
		endcase
	endtask

	task automatic return_to_hunting();
		while (phase_q != HUNT_FIRST) begin
			if (phase_q == READ_ID)
				send_byte(ID_BIG_ENDIAN);
			else
				send_byte(pick_other(hdr_first_q));
		end
	endtask

	task automatic test_reset_defaults();
		send_frame(8'd0, 16'd0);
		send_frame(ID_BIG_ENDIAN, 16'd0);
	endtask

	task automatic test_directed_frames();
		program_registers(RST_HEADER_FIRST, RST_HEADER_SECOND, 32'hFFFF_FFFF, RST_MAX_LENGTH);
		foreach (DIRECTED_BYTES[i])
			send_byte(DIRECTED_BYTES[i]);
	endtask

	task automatic test_length_limit();
		program_registers(RST_HEADER_FIRST, RST_HEADER_SECOND, 32'h0000_0004, 16'd1);
		send_frame(8'd2, 16'd1);
		send_frame(8'd2, 16'd2);
	endtask

	task automatic test_backpressure();
		int start;
		program_registers(RST_HEADER_FIRST, RST_HEADER_SECOND, 32'hFFFF_FFFF, RST_MAX_LENGTH);
		send_idle = 1'b0;
		fork
			begin
				result_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_hold = 1'b0;
			end
		join_none
		start = items_sent;
		while (items_sent - start < PRESSURE_ITEMS)
			send_frame(pick_id(), pick_length());
		send_idle = 1'b1;
	endtask

	task automatic run_random_phase(input logic [7:0] h1, input logic [7:0] h2,
			input logic [31:0] mask, input logic [15:0] max_len);
		int start;
		program_registers(h1, h2, mask, max_len);
		send_idle = 1'($urandom_range(0, 1));
		recv_idle = 1'($urandom_range(0, 1));
		start = items_sent;
		while (items_sent - start < RANDOM_PHASE_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				send_idle = !send_idle;
			if ($urandom_range(0, 15) == 0)
				recv_idle = !recv_idle;
			return_to_hunting();
			if ($urandom_range(0, 3) == 0)
				send_broken();
			else
				send_frame(pick_id(), pick_length());
		end
	endtask

	task automatic test_random_traffic();
		logic [7:0] same_hdr;
		same_hdr = 8'($urandom_range(0, 255));
		run_random_phase(RST_HEADER_FIRST, RST_HEADER_SECOND, 32'hFFFF_FFFF, 16'hFFFF);
		run_random_phase(8'h00, 8'hFF, $urandom(), 16'd0);
		run_random_phase(8'hFF, 8'h00, 32'h0, 16'd16);
		run_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom(),
			16'($urandom_range(1, 20)));
		run_random_phase(same_hdr, same_hdr, 32'h8000_0001, RST_MAX_LENGTH);
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		reset_parser_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_directed_frames();
		test_length_limit();
		test_backpressure();
		test_random_traffic();

		drain_results();
		if (err_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
